// File: rtl/core/iabd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and lookup tables for the IMA ADPCM byte decoder.
// No dependencies; every other file of the decoder depends on this package.
package iabd_pkg;

    localparam int IDX_MAX = 88;
    localparam int PCM_MAX = 32767;
    localparam int PCM_MIN = -32768;
    localparam int PCM_W   = 16;
    localparam int IDX_W   = 7;
    localparam int STEP_W  = 15;
    localparam int ADJ_W   = 5;

    typedef struct packed {
        logic signed [PCM_W-1:0] pred;
        logic [IDX_W-1:0]        idx;
    } iabd_chan_t;

    function automatic logic signed [ADJ_W-1:0] idx_adjust(input logic [2:0] mag);
        logic signed [ADJ_W-1:0] adj;
        begin
            case (mag)
                3'd4:    adj = 5'sd2;
                3'd5:    adj = 5'sd4;
                3'd6:    adj = 5'sd6;
                3'd7:    adj = 5'sd8;
                default: adj = -5'sd1;
            endcase
            return adj;
        end
    endfunction

    function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        begin
            case (idx)
                7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
                7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
                7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
                7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
                7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
                7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
                7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
                7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
                7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
                7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
                7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
                7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
                7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
                7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
                7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
                7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
                7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
                7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
                7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
                7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
                7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
                7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
                7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
                7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
                7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
                7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
                7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
                7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
                7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
                7'd87: s = 15'd29794;
                default: s = 15'd32767;
            endcase
            return s;
        end
    endfunction

endpackage

// File: rtl/core/iabd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for code bytes in and PCM samples out.
// Depends on iabd_pkg for the sample width.
interface iabd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       single_nibble;
    logic       restart;

    modport source (output valid, output code_byte, output single_nibble,
                    output restart, input ready);
    modport sink   (input valid, input code_byte, input single_nibble,
                    input restart, output ready);
endinterface

interface iabd_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [iabd_pkg::PCM_W-1:0]   first_sample;
    logic signed [iabd_pkg::PCM_W-1:0]   second_sample;
    logic                                second_valid;

    modport source (output valid, output first_sample, output second_sample,
                    output second_valid, input ready);
    modport sink   (input valid, input first_sample, input second_sample,
                    input second_valid, output ready);
endinterface

// File: rtl/core/iabd_lane.sv
`timescale 1ns / 1ps
// One decode lane: applies a 4-bit IMA code to a predictor and step index.
// Depends on iabd_pkg for the step and index tables.
module iabd_lane (
    input  logic [3:0]          code,
    input  iabd_pkg::iabd_chan_t chan_in,
    output iabd_pkg::iabd_chan_t chan_out
);
    import iabd_pkg::*;

    logic [IDX_W-1:0]        cur;
    logic [STEP_W-1:0]       step;
    logic [STEP_W+1:0]       diff;
    logic signed [PCM_W+1:0] pred_ext;
    logic signed [PCM_W+1:0] sum;
    logic signed [ADJ_W-1:0] adj;
    logic signed [IDX_W:0]   ni;

    always_comb
    begin
        cur  = (chan_in.idx > IDX_W'(IDX_MAX)) ? IDX_W'(IDX_MAX) : chan_in.idx;
        step = step_size(cur);
        diff = (STEP_W+2)'(step >> 3)
             + (code[2] ? (STEP_W+2)'(step) : '0)
             + (code[1] ? (STEP_W+2)'(step >> 1) : '0)
             + (code[0] ? (STEP_W+2)'(step >> 2) : '0);
        pred_ext = {{2{chan_in.pred[PCM_W-1]}}, chan_in.pred};
        if (code[3])
        begin
            sum = pred_ext - $signed({1'b0, diff});
        end
        else
        begin
            sum = pred_ext + $signed({1'b0, diff});
        end

        if (sum > (PCM_W+2)'(PCM_MAX))
        begin
            chan_out.pred = PCM_W'(PCM_MAX);
        end
        else if (sum < (PCM_W+2)'(PCM_MIN))
        begin
            chan_out.pred = PCM_W'(PCM_MIN);
        end
        else
        begin
            chan_out.pred = sum[PCM_W-1:0];
        end

        adj = idx_adjust(code[2:0]);
        ni  = $signed({1'b0, cur}) + {{(IDX_W+1-ADJ_W){adj[ADJ_W-1]}}, adj};
        if (ni < 0)
        begin
            chan_out.idx = '0;
        end
        else if (ni > (IDX_W+1)'(IDX_MAX))
        begin
            chan_out.idx = IDX_W'(IDX_MAX);
        end
        else
        begin
            chan_out.idx = ni[IDX_W-1:0];
        end
    end
endmodule

// File: rtl/core/iabd_merge.sv
`timescale 1ns / 1ps
// Merge stage: routes lane results into the channel state and the output register.
// Depends on iabd_pkg for the channel state type.
module iabd_merge (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic                          drain,
    input  logic                          stereo,
    input  logic                          single_nibble,
    input  logic                          restart,
    input  iabd_pkg::iabd_chan_t          lane_one,
    input  iabd_pkg::iabd_chan_t          lane_two,
    output iabd_pkg::iabd_chan_t          chan_one,
    output iabd_pkg::iabd_chan_t          chan_two,
    output logic                          res_valid,
    output logic signed [iabd_pkg::PCM_W-1:0] first_sample,
    output logic signed [iabd_pkg::PCM_W-1:0] second_sample,
    output logic                          second_valid
);
    import iabd_pkg::*;

    iabd_chan_t              chan_one_reg, chan_one_next;
    iabd_chan_t              chan_two_reg, chan_two_next;
    logic                    valid_reg, valid_next;
    logic signed [PCM_W-1:0] first_reg, second_reg;
    logic                    second_valid_reg;
    logic                    two_used;

    always_comb
    begin
        two_used      = stereo || !single_nibble;
        chan_one_next = chan_one_reg;
        chan_two_next = chan_two_reg;
        valid_next    = valid_reg;
        if (drain)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next = 1'b1;
            if (stereo)
            begin
                chan_one_next = lane_one;
                chan_two_next = lane_two;
            end
            else
            begin
                chan_one_next = single_nibble ? lane_one : lane_two;
                if (restart)
                begin
                    chan_two_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_one_reg <= '0;
            chan_two_reg <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            chan_one_reg <= chan_one_next;
            chan_two_reg <= chan_two_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            first_reg        <= lane_one.pred;
            second_reg       <= two_used ? lane_two.pred : '0;
            second_valid_reg <= two_used;
        end
    end

    assign chan_one      = chan_one_reg;
    assign chan_two      = chan_two_reg;
    assign res_valid     = valid_reg;
    assign first_sample  = first_reg;
    assign second_sample = second_reg;
    assign second_valid  = second_valid_reg;
endmodule

// File: rtl/core/ima_adpcm_byte_decoder_unit.sv
`timescale 1ns / 1ps
// IMA ADPCM byte decoder: one code byte in, up to two 16-bit PCM samples out per transfer.
// Depends on iabd_pkg, iabd_if, iabd_lane and iabd_merge.
//
// The decoder takes one code byte per clock cycle unless the output side stalls it, and
// returns its samples in the cycle after the input transfer, with a single output
// register between the two sides. Two decode lanes work side by side: in stereo mode each
// lane serves its own channel, and in mono mode the second lane continues from the first
// lane's result in the same cycle, so the two-step lane chain sets the clock period. The
// stereo_mode register must only be written while no transfer is in flight. A restart
// flag clears both channels before the byte that carries it is decoded.
module ima_adpcm_byte_decoder_unit (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_we,
    input  logic  cfg_wdata,
    iabd_in_if.sink    code_in,
    iabd_out_if.source pcm_out
);
    import iabd_pkg::*;

    logic       stereo_mode_reg;
    logic       take;
    iabd_chan_t chan_one;
    iabd_chan_t chan_two;
    iabd_chan_t lane_one_in;
    iabd_chan_t lane_two_in;
    iabd_chan_t lane_one_out;
    iabd_chan_t lane_two_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stereo_mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            stereo_mode_reg <= cfg_wdata;
        end
    end

    assign code_in.ready = !pcm_out.valid || pcm_out.ready;
    assign take          = code_in.valid && code_in.ready;

    always_comb
    begin
        lane_one_in = code_in.restart ? '0 : chan_one;
        if (stereo_mode_reg)
        begin
            lane_two_in = code_in.restart ? '0 : chan_two;
        end
        else
        begin
            lane_two_in = lane_one_out;
        end
    end

    iabd_lane u_lane_one (
        .code     (code_in.code_byte[7:4]),
        .chan_in  (lane_one_in),
        .chan_out (lane_one_out)
    );

    iabd_lane u_lane_two (
        .code     (code_in.code_byte[3:0]),
        .chan_in  (lane_two_in),
        .chan_out (lane_two_out)
    );

    iabd_merge u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .drain         (pcm_out.ready),
        .stereo        (stereo_mode_reg),
        .single_nibble (code_in.single_nibble),
        .restart       (code_in.restart),
        .lane_one      (lane_one_out),
        .lane_two      (lane_two_out),
        .chan_one      (chan_one),
        .chan_two      (chan_two),
        .res_valid     (pcm_out.valid),
        .first_sample  (pcm_out.first_sample),
        .second_sample (pcm_out.second_sample),
        .second_valid  (pcm_out.second_valid)
    );
endmodule
